[design/dma_pkg.sv]
// Shared types and constants for the decimating moving average.
// No dependencies; imported by the top level, dma_core and dma_outbuf.
package dma_pkg;

  localparam int SAMPLE_W     = 10;
  localparam int SUM_W        = 14;
  localparam int AVG_W        = 12;
  localparam int LEVEL_W      = 12;
  localparam int GROUP_W      = 4;
  localparam int GROUP_BLOCKS = 16;
  localparam int AVG_SHIFT    = 6;
  localparam int ROUND_BIAS   = 32;
  localparam int SUM_MAX      = 16383;
  localparam int AVG_MAX      = 4095;

  localparam int DEF_WINDOW_DEPTH = 16;
  localparam int DEF_BLOCK_LENGTH = 16;

  typedef enum logic {
    OP_SAMPLE  = 1'b0,
    OP_RESTART = 1'b1
  } op_t;

  typedef struct packed {
    logic [AVG_W-1:0] average;
    logic [SUM_W-1:0] block_sum;
    logic             group_end;
  } result_t;

endpackage

[design/decimating_moving_average.sv]
// Top level of the decimating moving average.
// Depends on dma_pkg, dma_core (with dma_ram) and dma_outbuf.
//
// Input channel (in_valid / in_stall, in_op, in_sample): one transaction per
// converter sample, or a restart that refills the window with the configured
// level times four. One transaction can be taken every cycle, unless in_stall.
// Result channel (out_valid / out_stall): one transaction per finished block of
// BLOCK_LENGTH samples, carrying the rounded window average, the block sum and
// a flag on every sixteenth result. When the last sample of a block is
// accepted, its result is registered in the output register or the skid entry.
// Configuration (cfg_valid / cfg_ready, cfg_data): the 12-bit restart level;
// cfg_ready is always high.
// Throughput is one item per cycle while in_stall is low, set by the update of
// the running window total against the window entry store, whose read is
// prefetched at the write pointer.
// Reset clears the level, block and group counts, the window total and the
// per-entry valid bits; the entry store itself is not swept, so the block is
// ready as soon as reset is released.
// When the receiver stalls, the result is held and one further result fits in
// a skid entry; in_stall rises only while that skid entry is occupied.
module decimating_moving_average
  import dma_pkg::*;
#(
  parameter int WINDOW_DEPTH = DEF_WINDOW_DEPTH,
  parameter int BLOCK_LENGTH = DEF_BLOCK_LENGTH
) (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                in_valid,
  output logic                in_stall,
  input  logic                in_op,
  input  logic [SAMPLE_W-1:0] in_sample,
  output logic                out_valid,
  input  logic                out_stall,
  output logic [AVG_W-1:0]    out_average,
  output logic [SUM_W-1:0]    out_block_sum,
  output logic                out_group_end,
  input  logic                cfg_valid,
  output logic                cfg_ready,
  input  logic [LEVEL_W-1:0]  cfg_data
);

  logic [LEVEL_W-1:0] level_r;
  logic               accept;
  logic               push;
  logic               full;
  result_t            result;
  result_t            out_data;

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      level_r <= '0;
    end else if (cfg_valid && cfg_ready) begin
      level_r <= cfg_data;
    end
  end

  assign in_stall = full;
  assign accept   = in_valid && !in_stall;

  dma_core #(
    .WINDOW_DEPTH (WINDOW_DEPTH),
    .BLOCK_LENGTH (BLOCK_LENGTH)
  ) u_core (
    .clk    (clk),
    .rst_n  (rst_n),
    .accept (accept),
    .op     (in_op),
    .sample (in_sample),
    .level  (level_r),
    .push   (push),
    .result (result)
  );

  dma_outbuf u_outbuf (
    .clk       (clk),
    .rst_n     (rst_n),
    .push      (push),
    .push_data (result),
    .full      (full),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_data  (out_data)
  );

  assign out_average   = out_data.average;
  assign out_block_sum = out_data.block_sum;
  assign out_group_end = out_data.group_end;

endmodule

[design/dma_ram.sv]
// Generic single-write, single-read RAM with registered read data.
// No dependencies.
module dma_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  logic                     clk,
  input  logic                     wr_en,
  input  logic [$clog2(DEPTH)-1:0] wr_addr,
  input  logic [WIDTH-1:0]         wr_data,
  input  logic [$clog2(DEPTH)-1:0] rd_addr,
  output logic [WIDTH-1:0]         rd_data
);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [WIDTH-1:0] rd_data_r;

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    rd_data_r <= mem[rd_addr];
  end

  assign rd_data = rd_data_r;

endmodule

[design/dma_core.sv]
// Block accumulator, window bookkeeping and rounding of the decimating average.
// Depends on dma_pkg and dma_ram (window entry store).
module dma_core
  import dma_pkg::*;
#(
  parameter int WINDOW_DEPTH = DEF_WINDOW_DEPTH,
  parameter int BLOCK_LENGTH = DEF_BLOCK_LENGTH
) (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                accept,
  input  logic                op,
  input  logic [SAMPLE_W-1:0] sample,
  input  logic [LEVEL_W-1:0]  level,
  output logic                push,
  output result_t             result
);

  localparam int POS_W   = $clog2(WINDOW_DEPTH);
  localparam int CNT_W   = $clog2(BLOCK_LENGTH);
  localparam int TOTAL_W = SUM_W + $clog2(WINDOW_DEPTH);
  localparam int RND_W   = (TOTAL_W + 1 > AVG_W + 1) ? TOTAL_W + 1 : AVG_W + 1;

  logic [SUM_W-1:0]        acc_r, acc_nxt;
  logic [CNT_W-1:0]        cnt_r, cnt_nxt;
  logic [POS_W-1:0]        pos_r, pos_nxt;
  logic [TOTAL_W-1:0]      total_r, total_nxt;
  logic [GROUP_W-1:0]      grp_r, grp_nxt;
  logic [SUM_W-1:0]        fill_r, fill_nxt;
  logic [WINDOW_DEPTH-1:0] valid_r, valid_nxt;

  logic               is_restart;
  logic               is_sample;
  logic               last;
  logic [SUM_W:0]     acc_sum;
  logic [SUM_W-1:0]   acc_sat;
  logic [SUM_W-1:0]   rd_data;
  logic [SUM_W-1:0]   old_entry;
  logic [SUM_W-1:0]   new_fill;
  logic [TOTAL_W-1:0] total_upd;
  logic [RND_W-1:0]   rnd;
  logic [RND_W-1:0]   avg_wide;
  logic [AVG_W-1:0]   avg;
  logic               wr_en;

  assign is_restart = accept && (op == OP_RESTART);
  assign is_sample  = accept && (op == OP_SAMPLE);
  assign last       = (cnt_r == CNT_W'(BLOCK_LENGTH - 1));

  assign acc_sum = {1'b0, acc_r} + (SUM_W + 1)'(sample);
  assign acc_sat = (acc_sum > (SUM_W + 1)'(SUM_MAX)) ? SUM_W'(SUM_MAX) : acc_sum[SUM_W-1:0];

  // Entries not written since the last restart (or reset) hold the fill level
  assign old_entry = valid_r[pos_r] ? rd_data : fill_r;
  assign total_upd = total_r - TOTAL_W'(old_entry) + TOTAL_W'(acc_sat);

  assign rnd      = RND_W'(total_upd) + RND_W'(ROUND_BIAS);
  assign avg_wide = rnd >> AVG_SHIFT;
  assign avg      = (avg_wide > RND_W'(AVG_MAX)) ? AVG_W'(AVG_MAX) : avg_wide[AVG_W-1:0];

  assign new_fill = {level, 2'b00};
  assign wr_en    = is_sample && last;

  dma_ram #(
    .WIDTH (SUM_W),
    .DEPTH (WINDOW_DEPTH)
  ) u_window (
    .clk     (clk),
    .wr_en   (wr_en),
    .wr_addr (pos_r),
    .wr_data (acc_sat),
    .rd_addr (pos_r),
    .rd_data (rd_data)
  );

  always_comb begin
    acc_nxt   = acc_r;
    cnt_nxt   = cnt_r;
    pos_nxt   = pos_r;
    total_nxt = total_r;
    grp_nxt   = grp_r;
    fill_nxt  = fill_r;
    valid_nxt = valid_r;
    if (is_restart) begin
      fill_nxt  = new_fill;
      valid_nxt = '0;
      total_nxt = TOTAL_W'(TOTAL_W'(new_fill) * TOTAL_W'(WINDOW_DEPTH));
    end else if (is_sample) begin
      if (last) begin
        acc_nxt         = '0;
        cnt_nxt         = '0;
        total_nxt       = total_upd;
        valid_nxt[pos_r] = 1'b1;
        pos_nxt         = (pos_r == POS_W'(WINDOW_DEPTH - 1)) ? '0 : pos_r + 1'b1;
        grp_nxt         = grp_r + 1'b1;
      end else begin
        acc_nxt = acc_sat;
        cnt_nxt = cnt_r + 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      acc_r   <= '0;
      cnt_r   <= '0;
      pos_r   <= '0;
      total_r <= '0;
      grp_r   <= '0;
      fill_r  <= '0;
      valid_r <= '0;
    end else begin
      acc_r   <= acc_nxt;
      cnt_r   <= cnt_nxt;
      pos_r   <= pos_nxt;
      total_r <= total_nxt;
      grp_r   <= grp_nxt;
      fill_r  <= fill_nxt;
      valid_r <= valid_nxt;
    end
  end

  assign push             = wr_en;
  assign result.average   = avg;
  assign result.block_sum = acc_sat;
  assign result.group_end = (grp_r == GROUP_W'(GROUP_BLOCKS - 1));

  a_pos_range: assert property (@(posedge clk) disable iff (!rst_n)
    pos_r <= POS_W'(WINDOW_DEPTH - 1))
    else $error("window pointer beyond depth");

  a_restart_keeps_block: assert property (@(posedge clk) disable iff (!rst_n)
    is_restart |=> $stable(cnt_r) && $stable(acc_r) && $stable(pos_r) && valid_r == '0)
    else $error("restart disturbed block in progress");

  a_push_clears_block: assert property (@(posedge clk) disable iff (!rst_n)
    push |=> cnt_r == '0 && acc_r == '0)
    else $error("block state not cleared after completion");

endmodule

[design/dma_outbuf.sv]
// Output register with one skid entry for the result channel.
// Depends on dma_pkg (result_t).
module dma_outbuf
  import dma_pkg::*;
(
  input  logic    clk,
  input  logic    rst_n,
  input  logic    push,
  input  result_t push_data,
  output logic    full,
  output logic    out_valid,
  input  logic    out_stall,
  output result_t out_data
);

  logic    out_valid_r, out_valid_nxt;
  logic    skid_valid_r, skid_valid_nxt;
  result_t out_r, out_nxt;
  result_t skid_r, skid_nxt;
  logic    pop;

  assign pop = out_valid_r && !out_stall;

  always_comb begin
    out_valid_nxt  = out_valid_r;
    skid_valid_nxt = skid_valid_r;
    out_nxt        = out_r;
    skid_nxt       = skid_r;
    if (!out_valid_r || pop) begin
      // Output slot free: drain the skid first, else take the new result
      if (skid_valid_r) begin
        out_nxt        = skid_r;
        out_valid_nxt  = 1'b1;
        skid_valid_nxt = 1'b0;
      end else begin
        out_nxt       = push_data;
        out_valid_nxt = push;
      end
    end else if (push) begin
      skid_nxt       = push_data;
      skid_valid_nxt = 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r  <= 1'b0;
      skid_valid_r <= 1'b0;
    end else begin
      out_valid_r  <= out_valid_nxt;
      skid_valid_r <= skid_valid_nxt;
    end
    out_r  <= out_nxt;
    skid_r <= skid_nxt;
  end

  assign full      = skid_valid_r;
  assign out_valid = out_valid_r;
  assign out_data  = out_r;

  a_skid_behind_out: assert property (@(posedge clk) disable iff (!rst_n)
    skid_valid_r |-> out_valid_r)
    else $error("skid holds a result ahead of the output register");

  a_no_push_when_full: assert property (@(posedge clk) disable iff (!rst_n)
    skid_valid_r |-> !push)
    else $error("result pushed while skid entry occupied");

endmodule
